### src/rbpg_pkg.sv
`timescale 1ns / 1ps
// Shared types, register map and arithmetic constants of the rainbow border pixel generator.
package rbpg_pkg;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int IDX_W = 10;

   localparam int DEG_FULL = 360;
   localparam int DEG_SECTOR = 60;

   localparam int MOD360_SHIFT = 33;
   localparam int MOD360_QUO_W = 17;
   localparam logic [24:0] MOD360_RECIP = 25'd23860929;

   localparam int DIV15_DEN = 15;
   localparam int DIV15_SHIFT = 16;
   localparam logic [12:0] DIV15_RECIP = 13'd4369;

   typedef enum logic [1:0] {
      CSR_PANEL_WIDTH  = 2'd0,
      CSR_PANEL_HEIGHT = 2'd1,
      CSR_BRIGHTNESS   = 2'd2,
      CSR_HUE_SPEED    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [8:0] panel_width;
      logic [8:0] panel_height;
      logic [7:0] brightness;
      logic [8:0] hue_speed;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      panel_width:  9'd64,
      panel_height: 9'd64,
      brightness:   8'd204,
      hue_speed:    9'd3
   };

   typedef struct packed {
      logic [15:0] frame_number;
      logic [9:0]  border_index;
   } req_type;

   typedef struct packed {
      logic [7:0] pixel_x;
      logic [7:0] pixel_y;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       out_of_range;
   } rsp_type;

   typedef struct packed {
      logic [8:0] hue_deg;
      logic [7:0] pixel_x;
      logic [7:0] pixel_y;
      logic       out_of_range;
   } carry_type;

endpackage

### src/rbpg_csr.sv
`timescale 1ns / 1ps
// APB-style configuration register file of the rainbow border pixel generator.
module rbpg_csr
   import rbpg_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type reg_index;

   always_comb begin
      reg_index = csr_index_type'(paddr[CSR_ADDR_W-1:2]);
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         case (reg_index)
            CSR_PANEL_WIDTH: begin
               cfg_in.panel_width = pwdata[8:0];
            end
            CSR_PANEL_HEIGHT: begin
               cfg_in.panel_height = pwdata[8:0];
            end
            CSR_BRIGHTNESS: begin
               cfg_in.brightness = pwdata[7:0];
            end
            CSR_HUE_SPEED: begin
               cfg_in.hue_speed = pwdata[8:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         CSR_PANEL_WIDTH: begin
            prdata = CSR_DATA_W'(cfg_ff.panel_width);
         end
         CSR_PANEL_HEIGHT: begin
            prdata = CSR_DATA_W'(cfg_ff.panel_height);
         end
         CSR_BRIGHTNESS: begin
            prdata = CSR_DATA_W'(cfg_ff.brightness);
         end
         CSR_HUE_SPEED: begin
            prdata = CSR_DATA_W'(cfg_ff.hue_speed);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign pready = 1'b1;
   assign cfg = cfg_ff;

endmodule

### src/rbpg_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider that spreads the hue offset along the perimeter.
module rbpg_div
   import rbpg_pkg::*;
#(
   parameter int NUM_W = 25,
   parameter int DEN_W = 12,
   parameter int QUO_W = 15
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   input  carry_type        in_carry,
   output logic             out_valid,
   output logic [QUO_W-1:0] quotient,
   output carry_type        out_carry
);

   logic             valid_ff [0:QUO_W];
   logic [QUO_W-1:0] quo_ff   [0:QUO_W];
   carry_type        carry_ff [0:QUO_W];
   logic [DEN_W-1:0] rem_ff   [0:QUO_W-1];
   logic [QUO_W-1:0] low_ff   [0:QUO_W-1];

   logic [DEN_W:0]   trial    [0:QUO_W-1];
   logic [DEN_W:0]   diff     [0:QUO_W-1];
   logic             take     [0:QUO_W-1];
   logic [DEN_W-1:0] rem_in   [0:QUO_W-1];

   always_comb begin
      for (int i = 0; i < QUO_W; i++) begin
         trial[i] = {rem_ff[i], low_ff[i][QUO_W-1]};
         diff[i] = trial[i] - {1'b0, denom};
         take[i] = (trial[i] >= {1'b0, denom});
         rem_in[i] = take[i] ? diff[i][DEN_W-1:0] : trial[i][DEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= QUO_W; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (enable) begin
         valid_ff[0] <= in_valid;
         for (int i = 0; i < QUO_W; i++) begin
            valid_ff[i+1] <= valid_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= DEN_W'(numer >> QUO_W);
         low_ff[0] <= numer[QUO_W-1:0];
         quo_ff[0] <= '0;
         carry_ff[0] <= in_carry;
         for (int i = 0; i < QUO_W - 1; i++) begin
            rem_ff[i+1] <= rem_in[i];
            low_ff[i+1] <= {low_ff[i][QUO_W-2:0], 1'b0};
         end
         for (int i = 0; i < QUO_W; i++) begin
            quo_ff[i+1] <= {quo_ff[i][QUO_W-2:0], take[i]};
            carry_ff[i+1] <= carry_ff[i];
         end
      end
   end

   assign out_valid = valid_ff[QUO_W];
   assign quotient = quo_ff[QUO_W];
   assign out_carry = carry_ff[QUO_W];

endmodule

### src/rbpg_color.sv
`timescale 1ns / 1ps
// Five-stage hue sum, sector split and full-saturation HSV to RGB conversion.
module rbpg_color
   import rbpg_pkg::*;
#(
   parameter int HUE_FRAC_BITS = 6,
   parameter int QUO_W = 15
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             in_valid,
   input  logic [QUO_W-1:0] spread,
   input  carry_type        in_carry,
   input  logic [7:0]       brightness,
   output logic             out_valid,
   output rsp_type          out_data
);

   localparam int HUE_FULL = DEG_FULL << HUE_FRAC_BITS;
   localparam int SEC_LEN = DEG_SECTOR << HUE_FRAC_BITS;
   localparam int HSW = QUO_W + 1;
   localparam int SW = $clog2(SEC_LEN + 1);
   localparam int PRW = 8 + SW;
   localparam int SCW = 12;

   typedef enum logic [2:0] {
      SECT_RED_YEL = 3'd0,
      SECT_YEL_GRN = 3'd1,
      SECT_GRN_CYN = 3'd2,
      SECT_CYN_BLU = 3'd3,
      SECT_BLU_MAG = 3'd4,
      SECT_MAG_RED = 3'd5
   } sector_type;

   logic             v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   carry_type        c1_ff, c2_ff, c3_ff, c4_ff;
   logic [QUO_W-1:0] hue_ff;
   sector_type       sec2_ff, sec3_ff, sec4_ff;
   logic [SW-1:0]    wsel_ff;
   logic [PRW-1:0]   prod_ff;
   logic [SCW-1:0]   scaled_ff;
   logic [7:0]       est_ff;
   rsp_type          out_ff;

   logic [HSW-1:0]   hsum;
   logic [QUO_W-1:0] hue_in;
   sector_type       sec_in;
   logic [QUO_W-1:0] base;
   logic [QUO_W-1:0] offset;
   logic [SW-1:0]    wsel_in;
   logic [PRW-1:0]   prod_in;
   logic [SCW-1:0]   scaled_in;
   logic [24:0]      est_prod;
   logic [7:0]       est_in;
   logic [SCW-1:0]   est_rem;
   logic [7:0]       second;
   rsp_type          out_in;

   always_comb begin
      hsum = (HSW'(in_carry.hue_deg) << HUE_FRAC_BITS) + HSW'(spread);
      if (hsum >= HSW'(HUE_FULL)) begin
         hsum = hsum - HSW'(HUE_FULL);
      end
      hue_in = hsum[QUO_W-1:0];
   end

   always_comb begin
      if (hue_ff < QUO_W'(SEC_LEN)) begin
         sec_in = SECT_RED_YEL;
         base = '0;
      end else if (hue_ff < QUO_W'(2 * SEC_LEN)) begin
         sec_in = SECT_YEL_GRN;
         base = QUO_W'(SEC_LEN);
      end else if (hue_ff < QUO_W'(3 * SEC_LEN)) begin
         sec_in = SECT_GRN_CYN;
         base = QUO_W'(2 * SEC_LEN);
      end else if (hue_ff < QUO_W'(4 * SEC_LEN)) begin
         sec_in = SECT_CYN_BLU;
         base = QUO_W'(3 * SEC_LEN);
      end else if (hue_ff < QUO_W'(5 * SEC_LEN)) begin
         sec_in = SECT_BLU_MAG;
         base = QUO_W'(4 * SEC_LEN);
      end else begin
         sec_in = SECT_MAG_RED;
         base = QUO_W'(5 * SEC_LEN);
      end
      offset = hue_ff - base;
      wsel_in = sec_in[0] ? (SW'(SEC_LEN) - SW'(offset)) : SW'(offset);
   end

   // The sector length is 15 * 2^(HUE_FRAC_BITS+2): shift first, then divide by 15.
   always_comb begin
      prod_in = PRW'(brightness) * PRW'(wsel_ff);
      scaled_in = SCW'(prod_ff >> (HUE_FRAC_BITS + 2));
      est_prod = 25'(scaled_in) * 25'(DIV15_RECIP);
      est_in = est_prod[DIV15_SHIFT +: 8];
      est_rem = scaled_ff - ({4'd0, est_ff} * SCW'(DIV15_DEN));
      second = (est_rem >= SCW'(DIV15_DEN)) ? (est_ff + 8'd1) : est_ff;
   end

   always_comb begin
      out_in.pixel_x = c4_ff.pixel_x;
      out_in.pixel_y = c4_ff.pixel_y;
      out_in.out_of_range = 1'b0;
      case (sec4_ff)
         SECT_RED_YEL: begin
            out_in.red = brightness;
            out_in.green = second;
            out_in.blue = 8'd0;
         end
         SECT_YEL_GRN: begin
            out_in.red = second;
            out_in.green = brightness;
            out_in.blue = 8'd0;
         end
         SECT_GRN_CYN: begin
            out_in.red = 8'd0;
            out_in.green = brightness;
            out_in.blue = second;
         end
         SECT_CYN_BLU: begin
            out_in.red = 8'd0;
            out_in.green = second;
            out_in.blue = brightness;
         end
         SECT_BLU_MAG: begin
            out_in.red = second;
            out_in.green = 8'd0;
            out_in.blue = brightness;
         end
         default: begin
            out_in.red = brightness;
            out_in.green = 8'd0;
            out_in.blue = second;
         end
      endcase
      if (c4_ff.out_of_range) begin
         out_in = '0;
         out_in.out_of_range = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (enable) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         hue_ff <= hue_in;
         c1_ff <= in_carry;
         sec2_ff <= sec_in;
         wsel_ff <= wsel_in;
         c2_ff <= c1_ff;
         prod_ff <= prod_in;
         sec3_ff <= sec2_ff;
         c3_ff <= c2_ff;
         scaled_ff <= scaled_in;
         sec4_ff <= sec3_ff;
         c4_ff <= c3_ff;
         est_ff <= est_in;
         out_ff <= out_in;
      end
   end

   assign out_valid = v5_ff;
   assign out_data = out_ff;

endmodule

### src/rbpg_obuf.sv
`timescale 1ns / 1ps
// Two-entry result buffer that decouples the pipeline from the result channel.
module rbpg_obuf
   import rbpg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic [1:0] count_ff;
   logic [1:0] count_in;
   rsp_type    head_ff;
   rsp_type    head_in;
   rsp_type    tail_ff;
   rsp_type    tail_in;
   logic       pop;

   always_comb begin
      pop = rsp_ready && (count_ff != 2'd0);
      count_in = count_ff + 2'(push) - 2'(pop);
      head_in = head_ff;
      tail_in = tail_ff;
      if (pop) begin
         head_in = (count_ff == 2'd2) ? tail_ff : push_data;
      end else if (count_ff == 2'd0) begin
         head_in = push_data;
      end
      if (push && !pop && (count_ff == 2'd1)) begin
         tail_in = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign full = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data = head_ff;

endmodule

### src/rainbow_border_pixel_gen.sv
`timescale 1ns / 1ps
// Top level of the rainbow border pixel generator.
// A beat accepted on the request channel passes the input registers a, b, c and d,
// the one-bit-per-stage perimeter divider, the colour stages and the result buffer.
// Throughput: one beat per cycle; req_ready falls only while two finished results wait.
// Reset is synchronous and active high; it clears every valid bit and the result buffer
// and loads the register reset values. No memories, so no clearing pass follows reset.
module rainbow_border_pixel_gen
   import rbpg_pkg::*;
#(
   parameter int HUE_FRAC_BITS = 6,
   parameter int MAX_SIDE = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int HUE_FULL = DEG_FULL << HUE_FRAC_BITS;
   localparam int QUO_W = $clog2(HUE_FULL);
   localparam int NUM_W = IDX_W + QUO_W;
   localparam int SIDE_W = $clog2(MAX_SIDE + 1);
   localparam int CW = ((SIDE_W > IDX_W) ? SIDE_W : IDX_W) + 2;

   cfg_type cfg;
   logic    adv;
   logic    buf_full;

   function automatic logic [CW-1:0] clamp_side(input logic [8:0] raw);
      logic [CW-1:0] v;
      begin
         v = CW'(raw);
         if (v < CW'(2)) begin
            v = CW'(2);
         end else if (v > CW'(MAX_SIDE)) begin
            v = CW'(MAX_SIDE);
         end
         return v;
      end
   endfunction

   rbpg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   logic [CW-1:0] side_w, side_h, perim, idx, bound_b, bound_c, pos_x, pos_y;
   logic [24:0]   a_fs_in;
   carry_type     a_carry_in;

   always_comb begin
      side_w = clamp_side(cfg.panel_width);
      side_h = clamp_side(cfg.panel_height);
      perim = ((side_w + side_h) << 1) - CW'(4);
      idx = CW'(req_data.border_index);
      bound_b = side_w + side_h - CW'(1);
      bound_c = (side_w << 1) + side_h - CW'(2);
      if (idx < side_w) begin
         pos_x = idx;
         pos_y = '0;
      end else if (idx < bound_b) begin
         pos_x = side_w - CW'(1);
         pos_y = idx - side_w + CW'(1);
      end else if (idx < bound_c) begin
         pos_x = bound_c - CW'(1) - idx;
         pos_y = side_h - CW'(1);
      end else begin
         pos_x = '0;
         pos_y = side_h - CW'(2) + bound_c - idx;
      end
      a_carry_in.hue_deg = '0;
      a_carry_in.pixel_x = pos_x[7:0];
      a_carry_in.pixel_y = pos_y[7:0];
      a_carry_in.out_of_range = (idx >= perim);
      a_fs_in = {9'd0, req_data.frame_number} * {16'd0, cfg.hue_speed};
   end

   logic             a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff;
   logic [24:0]      a_fs_ff, b_fs_ff;
   logic [IDX_W-1:0] a_idx_ff, b_idx_ff, c_idx_ff, d_idx_ff;
   carry_type        a_carry_ff, b_carry_ff, c_carry_ff, d_carry_ff;
   logic [MOD360_QUO_W-1:0] b_quo_ff;
   logic [9:0]       c_rem_ff;

   logic [49:0]             b_prod;
   logic [MOD360_QUO_W-1:0] b_quo_in;
   logic [24:0]             c_diff;
   logic [9:0]              c_rem_in;
   carry_type               d_carry_in;
   logic [NUM_W-1:0]        numer;

   // Frame hue modulo 360 by reciprocal estimate plus one correction step.
   always_comb begin
      b_prod = {25'd0, a_fs_ff} * {25'd0, MOD360_RECIP};
      b_quo_in = b_prod[MOD360_SHIFT +: MOD360_QUO_W];
      c_diff = b_fs_ff - ({8'd0, b_quo_ff} * 25'(DEG_FULL));
      c_rem_in = c_diff[9:0];
      d_carry_in = c_carry_ff;
      if (c_rem_ff >= 10'(DEG_FULL)) begin
         d_carry_in.hue_deg = 9'(c_rem_ff - 10'(DEG_FULL));
      end else begin
         d_carry_in.hue_deg = c_rem_ff[8:0];
      end
      numer = NUM_W'(d_idx_ff) * NUM_W'(HUE_FULL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_fs_ff <= a_fs_in;
         a_idx_ff <= req_data.border_index;
         a_carry_ff <= a_carry_in;
         b_fs_ff <= a_fs_ff;
         b_quo_ff <= b_quo_in;
         b_idx_ff <= a_idx_ff;
         b_carry_ff <= a_carry_ff;
         c_rem_ff <= c_rem_in;
         c_idx_ff <= b_idx_ff;
         c_carry_ff <= b_carry_ff;
         d_idx_ff <= c_idx_ff;
         d_carry_ff <= d_carry_in;
      end
   end

   logic             div_valid;
   logic [QUO_W-1:0] div_quo;
   carry_type        div_carry;

   rbpg_div #(
      .NUM_W (NUM_W),
      .DEN_W (CW),
      .QUO_W (QUO_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (d_valid_ff),
      .numer     (numer),
      .denom     (perim),
      .in_carry  (d_carry_ff),
      .out_valid (div_valid),
      .quotient  (div_quo),
      .out_carry (div_carry)
   );

   logic    col_valid;
   rsp_type col_data;

   rbpg_color #(
      .HUE_FRAC_BITS (HUE_FRAC_BITS),
      .QUO_W         (QUO_W)
   ) u_color (
      .clock      (clock),
      .reset      (reset),
      .enable     (adv),
      .in_valid   (div_valid),
      .spread     (div_quo),
      .in_carry   (div_carry),
      .brightness (cfg.brightness),
      .out_valid  (col_valid),
      .out_data   (col_data)
   );

   rbpg_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .push      (col_valid && adv),
      .push_data (col_data),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign adv = !buf_full;
   assign req_ready = adv;

`ifndef SYNTH
   a_stall_means_backlog : assert property (
      @(posedge clock) disable iff (reset) !req_ready |-> rsp_valid
   ) else $error("input stalled while no result beat was waiting");

   a_out_of_range_blank : assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.out_of_range) |->
         (rsp_data.red == 8'd0 && rsp_data.green == 8'd0 && rsp_data.blue == 8'd0 &&
          rsp_data.pixel_x == 8'd0 && rsp_data.pixel_y == 8'd0)
   ) else $error("out-of-range result beat carries nonzero fields");

   a_reset_empties : assert property (
      @(posedge clock) $past(reset) |-> !rsp_valid
   ) else $error("result beat offered right after reset");
`endif

endmodule
